/* rtl/core/log_page_record_scanner_top_macros.svh */
// ----------------------------------------------------------------------------
// Log page record scanner assertion macros
// Short forms for the concurrent checks in the scanner top level.
// ----------------------------------------------------------------------------
`ifndef LOG_PAGE_RECORD_SCANNER_TOP_MACROS_SVH
`define LOG_PAGE_RECORD_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define LPRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lprs: same-cycle check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define LPRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lprs: next-cycle check failed");

`endif

/* rtl/core/lprs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log page record scanner package
// Constants and the result type shared by the scanner modules.
// ----------------------------------------------------------------------------
package lprs_pkg;

	localparam logic [31:0] LOG_MAGIC = 32'h474F_4C41;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [12:0] END_START = 13'd8;
	localparam logic [12:0] END_MAX   = 13'h1FFF;
	localparam logic [8:0]  COUNT_MAX = 9'h1FF;

	typedef struct packed {
		logic        page_valid;
		logic [31:0] page_seq;
		logic [8:0]  record_count;
		logic [12:0] end_offset;
	} lprs_result_t;

endpackage

/* rtl/core/lprs_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16-CCITT byte update
// Folds one byte into the running CRC, MSB first, polynomial 0x1021.
// ----------------------------------------------------------------------------
module lprs_crc
	import lprs_pkg::*;
(
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

/* rtl/core/lprs_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log page record parser
// Holds the scan state and works out the effect of one page byte per cycle while take is high.
// ----------------------------------------------------------------------------
module lprs_parser
	import lprs_pkg::*;
#(
	parameter int PAGE_BYTES  = 4096,
	parameter int MAX_PAYLOAD = 200
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   data,
	input  logic         last,
	output lprs_result_t result
);

	localparam int PW  = $clog2(PAGE_BYTES + 1);
	localparam int GEW = (PW > 13) ? PW : 14;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_SEQ,
		PH_HDR,
		PH_PAYLOAD,
		PH_PAD
	} phase_t;

	localparam logic [GEW:0]   PAGE_LIMIT = (GEW + 1)'(PAGE_BYTES);
	localparam logic [GEW-1:0] GEND_RESET = GEW'(8);

	phase_t         phase_q, phase_n;
	logic [1:0]     cnt_q;
	logic [23:0]    shift_q, shift_n;
	logic [31:0]    seq_q, seq_n;
	logic           magic_ok_q, magic_ok_n;
	logic [7:0]     len_q, len_n;
	logic [15:0]    crc_exp_q, crc_exp_n;
	logic [15:0]    crc_q, crc_n;
	logic [7:0]     left_q, left_n;
	logic [1:0]     pad_q, pad_n;
	logic [8:0]     recs_q, recs_n;
	logic [GEW-1:0] gend_q, gend_n;
	logic           stopped_q, stopped_n;

	logic [15:0]    crc_upd;
	logic [31:0]    field;
	logic [8:0]     hdr_total;
	logic [8:0]     cur_total;

	lprs_crc u_crc (
		.crc_in  (crc_q),
		.data    (data),
		.crc_out (crc_upd)
	);

	// The last three bytes seen plus the current one form the 32-bit field.
	assign field     = {data, shift_q};
	assign hdr_total = 9'd4 + ((9'(field[7:0]) + 9'd3) & 9'h1FC);
	assign cur_total = 9'd4 + ((9'(len_q) + 9'd3) & 9'h1FC);

	always_comb begin
		phase_n    = phase_q;
		shift_n    = shift_q;
		seq_n      = seq_q;
		magic_ok_n = magic_ok_q;
		len_n      = len_q;
		crc_exp_n  = crc_exp_q;
		crc_n      = crc_q;
		left_n     = left_q;
		pad_n      = pad_q;
		recs_n     = recs_q;
		gend_n     = gend_q;
		stopped_n  = stopped_q;
		if (!stopped_q) begin
			case (phase_q)
				PH_MAGIC: begin
					shift_n = field[31:8];
					if (cnt_q == 2'd3) begin
						if (field == LOG_MAGIC) begin
							magic_ok_n = 1'b1;
							phase_n    = PH_SEQ;
						end else begin
							stopped_n = 1'b1;
						end
					end
				end
				PH_SEQ: begin
					seq_n = seq_q | (32'(data) << {cnt_q, 3'b000});
					if (cnt_q == 2'd3) begin
						shift_n = '0;
						phase_n = PH_HDR;
					end
				end
				PH_HDR: begin
					// Records start on word boundaries, so the offset counter
					// gives the position within the header directly.
					if (cnt_q == 2'd0 && ({1'b0, gend_q} + (GEW + 1)'(4)) > PAGE_LIMIT) begin
						stopped_n = 1'b1;
					end else begin
						shift_n = field[31:8];
						if (cnt_q == 2'd3) begin
							crc_exp_n = field[31:16];
							if (field[15:0] == 16'd0 ||
							    field[15:0] > 16'(MAX_PAYLOAD) ||
							    ({1'b0, gend_q} + (GEW + 1)'(hdr_total)) > PAGE_LIMIT) begin
								stopped_n = 1'b1;
							end else begin
								len_n   = field[7:0];
								crc_n   = CRC_INIT;
								left_n  = field[7:0];
								phase_n = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					crc_n  = crc_upd;
					left_n = left_q - 8'd1;
					if (left_q == 8'd1) begin
						if (crc_upd != crc_exp_q) begin
							stopped_n = 1'b1;
						end else if (len_q[1:0] == 2'd0) begin
							gend_n  = gend_q + GEW'(cur_total);
							recs_n  = (recs_q == COUNT_MAX) ? recs_q : recs_q + 9'd1;
							phase_n = PH_HDR;
						end else begin
							pad_n   = 2'd0 - len_q[1:0];
							phase_n = PH_PAD;
						end
					end
				end
				PH_PAD: begin
					pad_n = pad_q - 2'd1;
					if (pad_q == 2'd1) begin
						gend_n  = gend_q + GEW'(cur_total);
						recs_n  = (recs_q == COUNT_MAX) ? recs_q : recs_q + 9'd1;
						phase_n = PH_HDR;
					end
				end
				default: begin
					stopped_n = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		result.page_valid   = magic_ok_n;
		result.page_seq     = magic_ok_n ? seq_n : 32'd0;
		result.record_count = recs_n;
		result.end_offset   = (gend_n > GEW'(END_MAX)) ? END_MAX : gend_n[12:0];
	end

	// After the final byte of a page everything returns to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAGIC;
			cnt_q      <= 2'd0;
			shift_q    <= '0;
			seq_q      <= '0;
			magic_ok_q <= 1'b0;
			len_q      <= '0;
			crc_exp_q  <= '0;
			crc_q      <= CRC_INIT;
			left_q     <= '0;
			pad_q      <= '0;
			recs_q     <= '0;
			gend_q     <= GEND_RESET;
			stopped_q  <= 1'b0;
		end else if (take) begin
			if (last) begin
				phase_q    <= PH_MAGIC;
				cnt_q      <= 2'd0;
				shift_q    <= '0;
				seq_q      <= '0;
				magic_ok_q <= 1'b0;
				len_q      <= '0;
				crc_exp_q  <= '0;
				crc_q      <= CRC_INIT;
				left_q     <= '0;
				pad_q      <= '0;
				recs_q     <= '0;
				gend_q     <= GEND_RESET;
				stopped_q  <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				cnt_q      <= cnt_q + 2'd1;
				shift_q    <= shift_n;
				seq_q      <= seq_n;
				magic_ok_q <= magic_ok_n;
				len_q      <= len_n;
				crc_exp_q  <= crc_exp_n;
				crc_q      <= crc_n;
				left_q     <= left_n;
				pad_q      <= pad_n;
				recs_q     <= recs_n;
				gend_q     <= gend_n;
				stopped_q  <= stopped_n;
			end
		end
	end

endmodule

/* rtl/core/log_page_record_scanner_top.sv */
`timescale 1ns / 1ps
// The byte closing a page loads the result register as it leaves the input register.
// Throughput: one page byte per cycle unless held back; each taken byte updates the parser.
// A waiting result holds the input back only while the byte in the input register also
// closes a page.
// Reset (arst_n low, asynchronous) empties both stages and restarts the scan at offset zero.
// ----------------------------------------------------------------------------
// Log page record scanner top level
// Input register, byte parser and result register with valid/ready handshakes.
// ----------------------------------------------------------------------------
`include "log_page_record_scanner_top_macros.svh"
module log_page_record_scanner_top
	import lprs_pkg::*;
#(
	parameter int PAGE_BYTES  = 4096,
	parameter int MAX_PAYLOAD = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  page_byte,
	input  logic        page_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        page_valid,
	output logic [31:0] page_seq,
	output logic [8:0]  record_count,
	output logic [12:0] end_offset
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         advance_s1;
	logic         hold_s1;
	logic         load_s2;
	logic         valid_s2;
	logic         empty_res;
	lprs_result_t res;
	lprs_result_t res_s2;

	// A byte that closes the page needs the result register empty or being read out.
	assign advance_s1 = valid_s1 && (!last_s1 || !valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign load_s2    = advance_s1 && last_s1;
	assign hold_s1    = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= page_byte;
			last_s1 <= page_last;
		end
	end

	lprs_parser #(
		.PAGE_BYTES  (PAGE_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance_s1),
		.data   (byte_s1),
		.last   (last_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign page_valid   = res_s2.page_valid;
	assign page_seq     = res_s2.page_seq;
	assign record_count = res_s2.record_count;
	assign end_offset   = res_s2.end_offset;

	assign empty_res = (page_seq == 32'd0) && (record_count == 9'd0) && (end_offset == END_START);

	`LPRS_ASSERT_NEXT(a_last_gives_result, load_s2, valid_s2)
	`LPRS_ASSERT_NEXT(a_stalled_byte_held, hold_s1, valid_s1 && $stable({last_s1, byte_s1}))
	`LPRS_ASSERT_NOW(a_bad_magic_empty, valid_s2 && !page_valid, empty_res)
	`LPRS_ASSERT_NOW(a_no_records_at_start, valid_s2 && record_count == 9'd0, end_offset == END_START)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log page record scanner testbench
// Streams log pages through the scanner byte by byte. Pages mix
// well-formed ones with random records and broken, truncated and noise pages.
// A scan model predicts each page summary, and every summary from the block
// is checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import lprs_pkg::*;

	localparam int PAGE_LIMIT  = 4096;
	localparam int PAYLOAD_MAX = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 100;

	typedef enum logic [2:0] {
		ST_MAGIC,
		ST_SEQ,
		ST_HDR,
		ST_PAYLOAD,
		ST_PAD
	} scan_state_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         drain;
	} page_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  page_byte = 8'h00;
	logic        page_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        page_valid;
	logic [31:0] page_seq;
	logic [8:0]  record_count;
	logic [12:0] end_offset;

	// Scan model state
	scan_state_t scan_state;
	int unsigned offset_cnt;
	logic [31:0] shift_word;
	logic [31:0] seq_word;
	bit          magic_seen;
	logic [15:0] len_field;
	logic [15:0] crc_field;
	logic [15:0] crc_acc;
	int unsigned payload_cnt;
	int unsigned pad_cnt;
	int unsigned good_cnt;
	int unsigned good_end;
	bit          halted;

	lprs_result_t expected_summaries[$];
	page_item_t   stim_q[$];
	logic [7:0]   page_buf[$];
	bit           drain_next;

	int cycle_no = 0;
	int fail_count = 0;
	int pages_built = 0;
	int bytes_accepted = 0;
	int summaries_checked = 0;
	int valid_pages = 0;
	int most_records = 0;
	logic calm;

	assign calm = (cycle_no >= 2000) && (cycle_no < 5000);

	log_page_record_scanner_top #(
		.PAGE_BYTES (PAGE_LIMIT),
		.MAX_PAYLOAD(PAYLOAD_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.page_byte   (page_byte),
		.page_last   (page_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_valid  (page_valid),
		.page_seq    (page_seq),
		.record_count(record_count),
		.end_offset  (end_offset)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// Header plus payload rounded up to a whole word.
	function automatic int unsigned record_span(logic [15:0] len);
		return 4 + ((int'(len) + 3) & ~3);
	endfunction

	task automatic clear_scan();
		scan_state  = ST_MAGIC;
		offset_cnt  = 0;
		shift_word  = '0;
		seq_word    = '0;
		magic_seen  = 1'b0;
		len_field   = '0;
		crc_field   = '0;
		crc_acc     = CRC_INIT;
		payload_cnt = 0;
		pad_cnt     = 0;
		good_cnt    = 0;
		good_end    = END_START;
		halted      = 1'b0;
	endtask

	task automatic close_record();
		good_end += record_span(len_field);
		if (good_cnt < COUNT_MAX)
			good_cnt++;
		scan_state = ST_HDR;
	endtask

	task automatic scan_page_byte(input logic [7:0] b, input logic last);
		int unsigned k;
		lprs_result_t res;
		if (!halted) begin
			case (scan_state)
				ST_MAGIC: begin
					shift_word = {b, shift_word[31:8]};
					if (offset_cnt == 3) begin
						if (shift_word == LOG_MAGIC) begin
							magic_seen = 1'b1;
							scan_state = ST_SEQ;
						end else begin
							halted = 1'b1;
						end
					end
				end
				ST_SEQ: begin
					seq_word = seq_word | (32'(b) << (((offset_cnt - 4) & 3) * 8));
					if (offset_cnt == 7) begin
						shift_word = '0;
						scan_state = ST_HDR;
					end
				end
				ST_HDR: begin
					k = (offset_cnt - good_end) & 3;
					// A header that cannot fit in the page ends the scan at its first byte.
					if (k == 0 && good_end + 4 > PAGE_LIMIT) begin
						halted = 1'b1;
					end else begin
						shift_word = {b, shift_word[31:8]};
						if (k == 3) begin
							len_field = shift_word[15:0];
							crc_field = shift_word[31:16];
							if (len_field == 0 || len_field > PAYLOAD_MAX ||
									good_end + record_span(len_field) > PAGE_LIMIT) begin
								halted = 1'b1;
							end else begin
								crc_acc     = CRC_INIT;
								payload_cnt = len_field;
								scan_state  = ST_PAYLOAD;
							end
						end
					end
				end
				ST_PAYLOAD: begin
					crc_acc = crc_next(crc_acc, b);
					payload_cnt--;
					if (payload_cnt == 0) begin
						if (crc_acc != crc_field) begin
							halted = 1'b1;
						end else begin
							pad_cnt = (4 - (len_field & 3)) & 3;
							if (pad_cnt == 0)
								close_record();
							else
								scan_state = ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_cnt--;
					if (pad_cnt == 0)
						close_record();
				end
				default: begin
					halted = 1'b1;
				end
			endcase
		end
		if (offset_cnt < 32'h10_0000)
			offset_cnt++;
		if (last) begin
			res.page_valid   = magic_seen;
			res.page_seq     = magic_seen ? seq_word : 32'h0;
			res.record_count = 9'(good_cnt);
			res.end_offset   = (good_end > 32'(END_MAX)) ? END_MAX : 13'(good_end);
			expected_summaries.push_back(res);
			clear_scan();
		end
	endtask

	// Page construction helpers
	task automatic begin_page(input bit good_magic, input logic [31:0] seq);
		logic [31:0] magic;
		magic = LOG_MAGIC;
		if (!good_magic)
			magic = magic ^ (32'h1 << $urandom_range(0, 31));
		page_buf.delete();
		for (int i = 0; i < 4; i++)
			page_buf.push_back(magic[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			page_buf.push_back(seq[8 * i +: 8]);
	endtask

	task automatic add_record(input int unsigned len, input bit corrupt);
		logic [15:0] crc;
		logic [15:0] len16;
		logic [7:0]  body[$];
		logic [7:0]  b;
		len16 = 16'(len);
		crc   = CRC_INIT;
		if (len16 != 0 && len16 <= PAYLOAD_MAX) begin
			for (int i = 0; i < len16; i++) begin
				b = 8'($urandom);
				crc = crc_next(crc, b);
				body.push_back(b);
			end
			while (body.size() % 4 != 0)
				body.push_back(8'($urandom));
		end else begin
			crc = 16'($urandom);
		end
		if (corrupt)
			crc = crc ^ (16'h1 << $urandom_range(0, 15));
		page_buf.push_back(len16[7:0]);
		page_buf.push_back(len16[15:8]);
		page_buf.push_back(crc[7:0]);
		page_buf.push_back(crc[15:8]);
		foreach (body[i])
			page_buf.push_back(body[i]);
	endtask

	// Pads with erased or random bytes, or truncates, to the given length.
	task automatic finish_page(input int total);
		page_item_t it;
		while (page_buf.size() < total)
			page_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
		for (int i = 0; i < total; i++) begin
			it.b     = page_buf[i];
			it.last  = (i == total - 1);
			it.drain = drain_next && (i == 0);
			stim_q.push_back(it);
		end
		drain_next = 1'b0;
		pages_built++;
	endtask

	task automatic random_page();
		int r;
		int n;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			page_buf.delete();
			n = $urandom_range(1, 16);
			repeat (n) page_buf.push_back(8'($urandom));
			finish_page(n);
		end else begin
			begin_page(r >= 18, $urandom);
			n = $urandom_range(0, 5);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					len = 0;
				else if (r < 8)
					len = $urandom_range(PAYLOAD_MAX + 1, 65535);
				else if (r < 20)
					len = $urandom_range(1, PAYLOAD_MAX);
				else
					len = $urandom_range(1, 16);
				add_record(len, $urandom_range(0, 14) == 0);
			end
			if ($urandom_range(0, 99) < 60)
				finish_page(page_buf.size() + $urandom_range(0, 8));
			else
				finish_page($urandom_range(1, page_buf.size() + 4));
		end
	endtask

	task automatic build_stimulus();
		drain_next = 1'b0;
		// Directed pages: field extremes, bad magic, short pages, bad lengths and a bad CRC.
		begin_page(1, 32'hFFFF_FFFF);
		add_record(1, 0);
		add_record(4, 0);
		add_record(PAYLOAD_MAX, 0);
		finish_page(page_buf.size() + 4);
		begin_page(1, 32'h0);
		finish_page(8);
		begin_page(0, $urandom);
		add_record(8, 0);
		finish_page(page_buf.size());
		page_buf.delete();
		page_buf.push_back(8'h41);
		finish_page(1);
		begin_page(1, $urandom);
		finish_page(6);
		drain_next = 1'b1;
		begin_page(1, $urandom);
		finish_page(3);
		begin_page(1, $urandom);
		add_record(5, 0);
		add_record(0, 0);
		finish_page(page_buf.size() + 8);
		begin_page(1, $urandom);
		add_record(3, 0);
		add_record(PAYLOAD_MAX + 1, 0);
		finish_page(page_buf.size() + 4);
		begin_page(1, $urandom);
		add_record(7, 0);
		add_record(9, 1);
		finish_page(page_buf.size() + 4);
		begin_page(1, $urandom);
		add_record(10, 0);
		add_record(13, 0);
		finish_page(page_buf.size() - 5);
		begin_page(1, $urandom);
		add_record(16'hFFFF, 0);
		finish_page(page_buf.size());

		// Random part.
		while (stim_q.size() < 2000)
			random_page();
	endtask

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Request driver
	always @(posedge clk) begin : drive
		page_item_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			page_byte <= 8'h00;
			page_last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				scan_page_byte(page_byte, page_last);
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				// A page marked for draining waits until every summary has come back.
				if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30) &&
						!(stim_q[0].drain && expected_summaries.size() != 0)) begin
					nxt = stim_q.pop_front();
					in_valid  <= 1'b1;
					page_byte <= nxt.b;
					page_last <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	// Summary monitor
	always @(posedge clk) begin : watch
		lprs_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_summaries.size() == 0) begin
				report_mismatch($sformatf("unexpected summary valid=%0b seq=%h count=%0d end=%0d",
					page_valid, page_seq, record_count, end_offset));
			end else begin
				want = expected_summaries.pop_front();
				summaries_checked++;
				if (page_valid)
					valid_pages++;
				if (int'(record_count) > most_records)
					most_records = int'(record_count);
				if (page_valid !== want.page_valid)
					report_mismatch($sformatf("page_valid %0b, wanted %0b",
						page_valid, want.page_valid));
				if (page_seq !== want.page_seq)
					report_mismatch($sformatf("page_seq %h, wanted %h",
						page_seq, want.page_seq));
				if (record_count !== want.record_count)
					report_mismatch($sformatf("record_count %0d, wanted %0d",
						record_count, want.record_count));
				if (end_offset !== want.end_offset)
					report_mismatch($sformatf("end_offset %0d, wanted %0d",
						end_offset, want.end_offset));
			end
		end
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d summaries outstanding",
				cycle_no, expected_summaries.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clear_scan();
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_summaries.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("scanned %0d bytes in %0d pages; %0d summaries checked, %0d with a good header",
			bytes_accepted, pages_built, summaries_checked, valid_pages);
		$display("largest record count seen %0d; %0d mismatches", most_records, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
